// ===== rtl/clle_pkg.sv =====
// Package for the cursor linked-list engine.
// Holds the operation and status codes and the word layouts of both channels.
// No dependencies.
package clle_pkg;

  localparam int SLOTS_DEF = 128;

  localparam logic [2:0] OP_CREATE  = 3'd0;
  localparam logic [2:0] OP_INSERT  = 3'd1;
  localparam logic [2:0] OP_DELETE  = 3'd2;
  localparam logic [2:0] OP_GET     = 3'd3;
  localparam logic [2:0] OP_LOCATE  = 3'd4;
  localparam logic [2:0] OP_PRIOR   = 3'd5;
  localparam logic [2:0] OP_NEXT    = 3'd6;
  localparam logic [2:0] OP_LEN_CLR = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EXHAUST  = 2'd3;

  typedef struct packed {
    logic [2:0] operation;
    logic [6:0] list_head;
    logic [7:0] position;
    logic [7:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] slot_index;
    logic [7:0] result_value;
    logic [6:0] list_length;
  } out_word_t;

endpackage

// ===== rtl/clle_ifs.sv =====
// Valid/ready channel interfaces for the cursor linked-list engine.
// Depends on clle_pkg for the word layouts.
interface clle_in_if;
  logic               valid;
  logic               ready;
  clle_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface clle_out_if;
  logic                valid;
  logic                ready;
  clle_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/clle_pool.sv =====
// Slot pool of the cursor linked-list engine: cursor memory and data memory.
// Runs the pass that rebuilds the cursor chain after reset. Depends on nothing but its parameters.
module clle_pool #(
  parameter int  SLOTS = 128,
  parameter type req_t = logic
) (
  input  logic                       clk,
  input  logic                       rst,
  input  req_t                       req,
  output logic [$clog2(SLOTS)-1:0]   rd_cur,
  output logic [7:0]                 rd_dat,
  output logic                       init_busy
);

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  logic [IW-1:0] cur_mem [SLOTS];
  logic [7:0]    dat_mem [SLOTS];
  logic [IW-1:0] init_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_busy <= 1'b1;
      init_idx  <= '0;
    end else if (init_busy) begin
      if (init_idx == LAST) begin
        init_busy <= 1'b0;
      end else begin
        init_idx <= init_idx + 1'b1;
      end
    end
  end

  // The reset image chains every slot to the one after it; the last ends the chain.
  always_ff @(posedge clk) begin
    if (init_busy && !rst) begin
      cur_mem[init_idx] <= (init_idx == LAST) ? '0 : init_idx + 1'b1;
    end else if (req.cur_we) begin
      cur_mem[req.cur_wa] <= req.cur_wd;
    end
    rd_cur <= cur_mem[req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (req.dat_we) begin
      dat_mem[req.dat_wa] <= req.dat_wd;
    end
    rd_dat <= dat_mem[req.rd_addr];
  end

endmodule

// ===== rtl/cursor_linked_list_engine_unit.sv =====
// Cursor linked-list engine: one word in, one word out, pool walked one slot per cycle.
// Create takes the first free slot; locate, prior and next walk the list element by element;
// insert, delete and get count the list and then walk to the position.
// Throughput: one word at a time; the single-read-port cursor memory sets the walk rate.
// Reset (rst, synchronous) clears control and then runs a pass over every slot that rebuilds
// the free chain; no word is taken during that pass.
module cursor_linked_list_engine_unit #(
  parameter int SLOTS = clle_pkg::SLOTS_DEF
) (
  input logic       clk,
  input logic       rst,
  clle_in_if.sink   req,
  clle_out_if.source resp
);

  localparam int IW = $clog2(SLOTS);
  // Wide enough for positions, 7-bit heads and any slot count.
  localparam int XW = ((IW > 8) ? IW : 8) + 1;
  localparam logic [IW-1:0] LIM = IW'(SLOTS - 1);

  // Pool access for one cycle: one read address, one cursor write, one data write.
  typedef struct packed {
    logic [IW-1:0] rd_addr;
    logic          cur_we;
    logic [IW-1:0] cur_wa;
    logic [IW-1:0] cur_wd;
    logic          dat_we;
    logic [IW-1:0] dat_wa;
    logic [7:0]    dat_wd;
  } pool_req_t;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_START = 5'd1;
  localparam logic [4:0] S_CNT   = 5'd2;
  localparam logic [4:0] S_CHK   = 5'd3;
  localparam logic [4:0] S_TAKE1 = 5'd4;
  localparam logic [4:0] S_TAKE2 = 5'd5;
  localparam logic [4:0] S_CRE   = 5'd6;
  localparam logic [4:0] S_WALK0 = 5'd7;
  localparam logic [4:0] S_WALK  = 5'd8;
  localparam logic [4:0] S_INS2  = 5'd9;
  localparam logic [4:0] S_DEL1  = 5'd10;
  localparam logic [4:0] S_DEL2  = 5'd11;
  localparam logic [4:0] S_DEL3  = 5'd12;
  localparam logic [4:0] S_DEL4  = 5'd13;
  localparam logic [4:0] S_FHEAD = 5'd14;
  localparam logic [4:0] S_FLOOP = 5'd15;
  localparam logic [4:0] S_NEXT1 = 5'd16;
  localparam logic [4:0] S_PHEAD = 5'd17;
  localparam logic [4:0] S_PBODY = 5'd18;
  localparam logic [4:0] S_PTEST = 5'd19;
  localparam logic [4:0] S_CL0   = 5'd20;
  localparam logic [4:0] S_CL1   = 5'd21;
  localparam logic [4:0] S_CL2   = 5'd22;
  localparam logic [4:0] S_CL3   = 5'd23;
  localparam logic [4:0] S_CLW   = 5'd24;
  localparam logic [4:0] S_DONE  = 5'd25;

  // Truncates a slot number or a count to the 7-bit result fields.
  function automatic logic [6:0] to7(input logic [IW-1:0] x);
    logic [XW-1:0] t;
    t = XW'(x);
    return t[6:0];
  endfunction

  logic [4:0]    state, state_next;
  logic [2:0]    op, op_next;
  logic [IW-1:0] head, head_next;
  logic          head_bad, head_bad_next;
  logic [7:0]    pos, pos_next;
  logic [7:0]    val, val_next;
  logic [IW-1:0] ptr, ptr_next;
  logic [IW-1:0] jreg, jreg_next;
  logic [IW-1:0] n, n_next;
  logic [IW-1:0] steps, steps_next;
  logic [7:0]    jdata, jdata_next;
  logic [1:0]    st, st_next;
  logic [6:0]    slot, slot_next;
  logic [7:0]    rval, rval_next;
  logic [6:0]    len, len_next;
  logic          ovalid, ovalid_next;
  clle_pkg::out_word_t odata, odata_next;

  pool_req_t     pr;
  logic [IW-1:0] rc;
  logic [7:0]    rdat;
  logic          init_busy;

  logic [XW-1:0] pos_x, n_x, head_in_x;
  logic [IW-1:0] n_inc;

  clle_pool #(.SLOTS(SLOTS), .req_t(pool_req_t)) u_pool (
    .clk       (clk),
    .rst       (rst),
    .req       (pr),
    .rd_cur    (rc),
    .rd_dat    (rdat),
    .init_busy (init_busy)
  );

  assign pos_x     = XW'(pos);
  assign n_x       = XW'(n);
  assign head_in_x = XW'(req.data.list_head);
  assign n_inc     = n + 1'b1;

  // A new word is taken only when the sequencer is parked and the pool is built.
  assign req.ready  = (state == S_IDLE) && !init_busy;
  assign resp.valid = ovalid;
  assign resp.data  = odata;

  always_comb begin
    state_next    = state;
    op_next       = op;
    head_next     = head;
    head_bad_next = head_bad;
    pos_next      = pos;
    val_next      = val;
    ptr_next      = ptr;
    jreg_next     = jreg;
    n_next        = n;
    steps_next    = steps;
    jdata_next    = jdata;
    st_next       = st;
    slot_next     = slot;
    rval_next     = rval;
    len_next      = len;
    ovalid_next   = ovalid && !resp.ready;
    odata_next    = odata;
    pr            = '0;
    pr.rd_addr    = ptr;

    unique case (state)
      S_IDLE: begin
        if (req.valid && req.ready) begin
          op_next       = req.data.operation;
          head_next     = head_in_x[IW-1:0];
          head_bad_next = head_in_x >= XW'(SLOTS);
          pos_next      = req.data.position;
          val_next      = req.data.value;
          st_next       = clle_pkg::ST_OK;
          slot_next     = '0;
          rval_next     = '0;
          len_next      = '0;
          state_next    = S_START;
        end
      end

      S_START: begin
        n_next     = '0;
        pr.rd_addr = head;
        if (op != clle_pkg::OP_CREATE && head_bad) begin
          st_next    = clle_pkg::ST_RANGE;
          state_next = S_DONE;
        end else begin
          unique case (op) inside
            clle_pkg::OP_CREATE: begin
              pr.rd_addr = '0;
              state_next = S_TAKE1;
            end
            clle_pkg::OP_INSERT, clle_pkg::OP_DELETE, clle_pkg::OP_GET: begin
              state_next = S_CNT;
            end
            clle_pkg::OP_LOCATE, clle_pkg::OP_NEXT: begin
              state_next = S_FHEAD;
            end
            clle_pkg::OP_PRIOR: begin
              state_next = S_PHEAD;
            end
            default: begin
              if (pos == 8'd0) begin
                state_next = S_CNT;
              end else if (pos == 8'd1) begin
                state_next = S_CL0;
              end else begin
                st_next    = clle_pkg::ST_RANGE;
                state_next = S_DONE;
              end
            end
          endcase
        end
      end

      // Bounded count: rc is the cursor of the last node reached.
      S_CNT: begin
        if (rc == '0 || n == LIM) begin
          state_next = S_CHK;
        end else begin
          n_next     = n_inc;
          pr.rd_addr = rc;
        end
      end

      S_CHK: begin
        pr.rd_addr = head;
        ptr_next   = head;
        if (op == clle_pkg::OP_LEN_CLR) begin
          len_next   = to7(n);
          state_next = S_DONE;
        end else if (op == clle_pkg::OP_INSERT) begin
          if (pos_x == '0 || pos_x > n_x + 1'b1) begin
            st_next    = clle_pkg::ST_RANGE;
            state_next = S_DONE;
          end else begin
            pr.rd_addr = '0;
            state_next = S_TAKE1;
          end
        end else if (pos_x == '0 || pos_x > n_x) begin
          st_next    = clle_pkg::ST_RANGE;
          state_next = S_DONE;
        end else begin
          steps_next = (op == clle_pkg::OP_DELETE) ? IW'(pos_x - 1'b1) : pos_x[IW-1:0];
          state_next = S_WALK;
        end
      end

      // rc holds the first free slot.
      S_TAKE1: begin
        if (rc == '0) begin
          st_next    = clle_pkg::ST_EXHAUST;
          state_next = S_DONE;
        end else begin
          jreg_next  = rc;
          pr.rd_addr = rc;
          state_next = S_TAKE2;
        end
      end

      S_TAKE2: begin
        pr.cur_we = 1'b1;
        pr.cur_wa = '0;
        pr.cur_wd = rc;
        if (op == clle_pkg::OP_CREATE) begin
          state_next = S_CRE;
        end else begin
          pr.dat_we  = 1'b1;
          pr.dat_wa  = jreg;
          pr.dat_wd  = val;
          state_next = S_WALK0;
        end
      end

      S_CRE: begin
        pr.cur_we  = 1'b1;
        pr.cur_wa  = jreg;
        pr.cur_wd  = '0;
        slot_next  = to7(jreg);
        state_next = S_DONE;
      end

      // The walk starts only after the free-list head was rewritten.
      S_WALK0: begin
        pr.rd_addr = head;
        ptr_next   = head;
        steps_next = IW'(pos_x - 1'b1);
        state_next = S_WALK;
      end

      // rc and rdat belong to the slot in ptr.
      S_WALK: begin
        if (steps == '0) begin
          if (op == clle_pkg::OP_INSERT) begin
            pr.cur_we  = 1'b1;
            pr.cur_wa  = jreg;
            pr.cur_wd  = rc;
            state_next = S_INS2;
          end else if (op == clle_pkg::OP_DELETE) begin
            jreg_next  = rc;
            pr.rd_addr = rc;
            state_next = S_DEL1;
          end else begin
            rval_next  = rdat;
            state_next = S_DONE;
          end
        end else begin
          ptr_next   = rc;
          steps_next = steps - 1'b1;
          pr.rd_addr = rc;
        end
      end

      S_INS2: begin
        pr.cur_we  = 1'b1;
        pr.cur_wa  = ptr;
        pr.cur_wd  = jreg;
        state_next = S_DONE;
      end

      S_DEL1: begin
        pr.cur_we  = 1'b1;
        pr.cur_wa  = ptr;
        pr.cur_wd  = rc;
        rval_next  = rdat;
        state_next = S_DEL2;
      end

      S_DEL2: begin
        pr.rd_addr = '0;
        state_next = S_DEL3;
      end

      S_DEL3: begin
        pr.cur_we  = 1'b1;
        pr.cur_wa  = jreg;
        pr.cur_wd  = rc;
        state_next = S_DEL4;
      end

      S_DEL4: begin
        pr.cur_we  = 1'b1;
        pr.cur_wa  = '0;
        pr.cur_wd  = jreg;
        state_next = S_DONE;
      end

      S_FHEAD: begin
        n_next = '0;
        if (rc == '0) begin
          st_next    = clle_pkg::ST_NOTFOUND;
          state_next = S_DONE;
        end else begin
          ptr_next   = rc;
          pr.rd_addr = rc;
          state_next = S_FLOOP;
        end
      end

      S_FLOOP: begin
        if (rdat == val) begin
          if (op == clle_pkg::OP_LOCATE) begin
            slot_next  = to7(ptr);
            state_next = S_DONE;
          end else if (rc == '0) begin
            st_next    = clle_pkg::ST_NOTFOUND;
            state_next = S_DONE;
          end else begin
            pr.rd_addr = rc;
            state_next = S_NEXT1;
          end
        end else if (n == LIM || rc == '0) begin
          st_next    = clle_pkg::ST_NOTFOUND;
          state_next = S_DONE;
        end else begin
          n_next     = n_inc;
          ptr_next   = rc;
          pr.rd_addr = rc;
        end
      end

      S_NEXT1: begin
        rval_next  = rdat;
        state_next = S_DONE;
      end

      S_PHEAD: begin
        n_next = '0;
        if (rc == '0) begin
          st_next    = clle_pkg::ST_NOTFOUND;
          state_next = S_DONE;
        end else begin
          ptr_next   = rc;
          pr.rd_addr = rc;
          state_next = S_PBODY;
        end
      end

      // The first element is stepped over without a compare: it has no predecessor.
      S_PBODY: begin
        jdata_next = rdat;
        n_next     = n_inc;
        if (rc == '0) begin
          st_next    = clle_pkg::ST_NOTFOUND;
          state_next = S_DONE;
        end else begin
          ptr_next   = rc;
          pr.rd_addr = rc;
          state_next = S_PTEST;
        end
      end

      S_PTEST: begin
        if (rdat == val) begin
          rval_next  = jdata;
          state_next = S_DONE;
        end else if (n == LIM || rc == '0) begin
          st_next    = clle_pkg::ST_NOTFOUND;
          state_next = S_DONE;
        end else begin
          jdata_next = rdat;
          n_next     = n_inc;
          ptr_next   = rc;
          pr.rd_addr = rc;
        end
      end

      // Clear: detach the chain from the head, then splice it onto the free list.
      S_CL0: begin
        if (rc == '0) begin
          state_next = S_DONE;
        end else begin
          ptr_next   = rc;
          pr.cur_we  = 1'b1;
          pr.cur_wa  = head;
          pr.cur_wd  = '0;
          state_next = S_CL1;
        end
      end

      S_CL1: begin
        pr.rd_addr = '0;
        state_next = S_CL2;
      end

      S_CL2: begin
        jreg_next  = rc;
        pr.cur_we  = 1'b1;
        pr.cur_wa  = '0;
        pr.cur_wd  = ptr;
        state_next = S_CL3;
      end

      S_CL3: begin
        pr.rd_addr = ptr;
        n_next     = '0;
        state_next = S_CLW;
      end

      S_CLW: begin
        if (rc == '0 || n_inc == LIM) begin
          pr.cur_we  = 1'b1;
          pr.cur_wa  = ptr;
          pr.cur_wd  = jreg;
          state_next = S_DONE;
        end else begin
          n_next     = n_inc;
          ptr_next   = rc;
          pr.rd_addr = rc;
        end
      end

      S_DONE: begin
        if (!ovalid || resp.ready) begin
          ovalid_next             = 1'b1;
          odata_next.status       = st;
          odata_next.slot_index   = slot;
          odata_next.result_value = rval;
          odata_next.list_length  = len;
          state_next              = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      ovalid <= ovalid_next;
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    head     <= head_next;
    head_bad <= head_bad_next;
    pos      <= pos_next;
    val      <= val_next;
    ptr      <= ptr_next;
    jreg     <= jreg_next;
    n        <= n_next;
    steps    <= steps_next;
    jdata    <= jdata_next;
    st       <= st_next;
    slot     <= slot_next;
    rval     <= rval_next;
    len      <= len_next;
    odata    <= odata_next;
  end

endmodule

// ===== rtl/clle_checker.sv =====
// Port-level checks for the cursor linked-list engine, bound to the top level.
// Depends on clle_pkg and cursor_linked_list_engine_unit.
module clle_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_ready,
  input logic                resp_valid,
  input logic                resp_ready,
  input clle_pkg::out_word_t resp_data
);

  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_ready |=> resp_valid)
    else $error("result word dropped while stalled");

  a_resp_stable: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_ready |=> $stable(resp_data))
    else $error("result word changed while stalled");

  a_no_take_after_reset: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("word taken while the pool is being rebuilt");

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (rst)
    resp_valid && resp_data.status != clle_pkg::ST_OK |->
      resp_data.slot_index == '0 && resp_data.result_value == '0 &&
      resp_data.list_length == '0)
    else $error("failed word carries a nonzero field");

endmodule

bind cursor_linked_list_engine_unit clle_checker u_clle_checker (
  .clk        (clk),
  .rst        (rst),
  .req_ready  (req.ready),
  .resp_valid (resp.valid),
  .resp_ready (resp.ready),
  .resp_data  (resp.data)
);

// ===== tb/tb_cursor_linked_list_engine_unit.sv =====
// Self-checking testbench for the cursor linked-list engine.
// Depends on clle_pkg, the clle_in_if/clle_out_if channel interfaces and the engine RTL.
module tb_cursor_linked_list_engine_unit;

  localparam int SLOTS      = clle_pkg::SLOTS_DEF;
  localparam int WALK_LIMIT = SLOTS - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;

  clle_in_if  req_if ();
  clle_out_if resp_if ();

  cursor_linked_list_engine_unit #(.SLOTS(SLOTS)) u_dut (
    .clk  (clk),
    .rst  (rst),
    .req  (req_if.sink),
    .resp (resp_if.source)
  );

  always #5 clk = ~clk;

  // Shadow copy of the pool. Data slots are only ever read after an insert wrote them,
  // because the stimulus only names real list heads.
  int                  shadow_next [SLOTS];
  logic [7:0]          shadow_data [SLOTS];
  clle_pkg::out_word_t awaited_words [$];
  int                  list_heads [$];
  int                  error_count = 0;
  bit                  no_idle = 1'b0;
  int                  hold_cycles = 0;

  // Chooses an idle gap: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int chain_length(int head);
    int n = 0;
    int i = shadow_next[head];
    while (i != 0 && n < WALK_LIMIT) begin
      n++;
      i = shadow_next[i];
    end
    return n;
  endfunction

  function automatic int hop(int k, int steps);
    repeat (steps) k = shadow_next[k];
    return k;
  endfunction

  function automatic int seek_value(int head, logic [7:0] v);
    int i = shadow_next[head];
    int n = 0;
    while (i != 0 && shadow_data[i] != v && n < WALK_LIMIT) begin
      i = shadow_next[i];
      n++;
    end
    return (i != 0 && shadow_data[i] == v) ? i : 0;
  endfunction

  function automatic int free_count();
    return chain_length(0);
  endfunction

  // Computes the response word for one request and advances the shadow pool.
  function automatic clle_pkg::out_word_t predict_response(clle_pkg::in_word_t w);
    clle_pkg::out_word_t r;
    int h, p, n, i, j, k;
    r = '0;
    h = w.list_head;
    p = w.position;
    // A 7-bit head can never reach SLOTS here, so the out-of-pool check never fires.
    case (w.operation)
      clle_pkg::OP_CREATE: begin
        j = shadow_next[0];
        if (j == 0) begin
          r.status = clle_pkg::ST_EXHAUST;
        end else begin
          shadow_next[0] = shadow_next[j];
          shadow_next[j] = 0;
          r.slot_index = 7'(j);
        end
      end
      clle_pkg::OP_INSERT: begin
        n = chain_length(h);
        if (p < 1 || p > n + 1) begin
          r.status = clle_pkg::ST_RANGE;
        end else begin
          j = shadow_next[0];
          if (j == 0) begin
            r.status = clle_pkg::ST_EXHAUST;
          end else begin
            shadow_next[0] = shadow_next[j];
            shadow_data[j] = w.value;
            k = hop(h, p - 1);
            shadow_next[j] = shadow_next[k];
            shadow_next[k] = j;
          end
        end
      end
      clle_pkg::OP_DELETE: begin
        n = chain_length(h);
        if (p < 1 || p > n) begin
          r.status = clle_pkg::ST_RANGE;
        end else begin
          k = hop(h, p - 1);
          j = shadow_next[k];
          shadow_next[k] = shadow_next[j];
          r.result_value = shadow_data[j];
          shadow_next[j] = shadow_next[0];
          shadow_next[0] = j;
        end
      end
      clle_pkg::OP_GET: begin
        n = chain_length(h);
        if (p < 1 || p > n) r.status = clle_pkg::ST_RANGE;
        else r.result_value = shadow_data[hop(h, p)];
      end
      clle_pkg::OP_LOCATE: begin
        r.slot_index = 7'(seek_value(h, w.value));
        if (r.slot_index == 0) r.status = clle_pkg::ST_NOTFOUND;
      end
      clle_pkg::OP_PRIOR: begin
        // The first element is never compared, so it has no predecessor.
        i = shadow_next[h];
        j = i;
        n = 0;
        if (i != 0) begin
          do begin
            j = i;
            i = shadow_next[i];
            n++;
          end while (i != 0 && shadow_data[i] != w.value && n < WALK_LIMIT);
        end
        if (i != 0 && shadow_data[i] == w.value) r.result_value = shadow_data[j];
        else r.status = clle_pkg::ST_NOTFOUND;
      end
      clle_pkg::OP_NEXT: begin
        i = seek_value(h, w.value);
        i = (i != 0) ? shadow_next[i] : 0;
        if (i != 0) r.result_value = shadow_data[i];
        else r.status = clle_pkg::ST_NOTFOUND;
      end
      default: begin
        if (p == 0) begin
          r.list_length = 7'(chain_length(h));
        end else if (p == 1) begin
          // Splice the whole chain onto the front of the free list; an empty list is a no-op.
          i = shadow_next[h];
          if (i != 0) begin
            shadow_next[h] = 0;
            k = shadow_next[0];
            shadow_next[0] = i;
            j = i;
            n = 0;
            while (i != 0 && n < WALK_LIMIT) begin
              j = i;
              i = shadow_next[i];
              n++;
            end
            shadow_next[j] = k;
          end
        end else begin
          r.status = clle_pkg::ST_RANGE;
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch in %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  // Offers one request word after a random gap and predicts its response once it is taken.
  task automatic send_word(input logic [2:0] op, input int head, input int pos,
                           input int val);
    clle_pkg::in_word_t  w;
    clle_pkg::out_word_t r;
    int gap;
    w.operation = op;
    w.list_head = head[6:0];
    w.position  = pos[7:0];
    w.value     = val[7:0];
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
    end
    @(negedge clk);
    req_if.valid <= 1'b1;
    req_if.data  <= w;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    r = predict_response(w);
    awaited_words.push_back(r);
    if (op == clle_pkg::OP_CREATE && r.status == clle_pkg::ST_OK)
      list_heads.push_back(r.slot_index);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
  endtask

  // Picks a value that is in the list about half of the time.
  function automatic int pick_value(int head);
    int n = chain_length(head);
    if (n > 0 && $urandom_range(0, 1) == 1)
      return shadow_data[hop(head, $urandom_range(1, n))];
    return $urandom_range(0, 255);
  endfunction

  task automatic test_directed();
    int h, g;
    send_word(clle_pkg::OP_CREATE, 7'h7f, 8'hff, 8'hff);
    h = list_heads[0];
    send_word(clle_pkg::OP_CREATE, 0, 0, 0);
    g = list_heads[1];
    // Empty list: length zero, clear as a no-op, prior and next find nothing.
    send_word(clle_pkg::OP_LEN_CLR, h, 0, 0);
    send_word(clle_pkg::OP_LEN_CLR, h, 1, 0);
    send_word(clle_pkg::OP_PRIOR, h, 0, 0);
    send_word(clle_pkg::OP_NEXT, h, 0, 0);
    send_word(clle_pkg::OP_GET, h, 1, 0);
    send_word(clle_pkg::OP_INSERT, h, 1, 8'h00);
    send_word(clle_pkg::OP_INSERT, h, 2, 8'hff);
    send_word(clle_pkg::OP_INSERT, h, 2, 8'h55);
    send_word(clle_pkg::OP_INSERT, h, 0, 8'haa);
    send_word(clle_pkg::OP_INSERT, h, 5, 8'haa);
    send_word(clle_pkg::OP_GET, h, 3, 0);
    send_word(clle_pkg::OP_GET, h, 128, 0);
    send_word(clle_pkg::OP_GET, h, 255, 0);
    send_word(clle_pkg::OP_LOCATE, h, 0, 8'h55);
    send_word(clle_pkg::OP_LOCATE, h, 0, 8'h12);
    // The first element has no predecessor and the last has no successor.
    send_word(clle_pkg::OP_PRIOR, h, 0, 8'h00);
    send_word(clle_pkg::OP_PRIOR, h, 0, 8'hff);
    send_word(clle_pkg::OP_NEXT, h, 0, 8'hff);
    send_word(clle_pkg::OP_NEXT, h, 0, 8'h00);
    send_word(clle_pkg::OP_LEN_CLR, h, 2, 0);
    send_word(clle_pkg::OP_DELETE, h, 4, 0);
    send_word(clle_pkg::OP_DELETE, h, 1, 0);
    send_word(clle_pkg::OP_LEN_CLR, g, 0, 0);
    send_word(clle_pkg::OP_LEN_CLR, h, 0, 0);
  endtask

  // Fills one list from the front until the pool runs dry, then hands it all back.
  task automatic test_pool_exhaustion();
    int h;
    h = list_heads[1];
    while (free_count() > 0)
      send_word(clle_pkg::OP_INSERT, h, 1, $urandom_range(0, 255));
    send_word(clle_pkg::OP_INSERT, h, 1, 8'h3c);
    send_word(clle_pkg::OP_CREATE, 0, 0, 0);
    send_word(clle_pkg::OP_LEN_CLR, h, 0, 0);
    send_word(clle_pkg::OP_GET, h, chain_length(h), 0);
    send_word(clle_pkg::OP_LEN_CLR, h, 1, 0);
    // Cleared slots sit at the front of the free list, so new heads take high indexes.
    send_word(clle_pkg::OP_CREATE, 0, 0, 0);
    send_word(clle_pkg::OP_CREATE, 0, 0, 0);
  endtask

  // The receiver holds off while requests keep coming, so the engine stalls its input.
  task automatic test_backpressure();
    int h;
    h = list_heads[0];
    hold_cycles = 600;
    repeat (12) send_word(clle_pkg::OP_INSERT, h, 1, $urandom_range(0, 255));
  endtask

  task automatic test_drain_pause();
    int h;
    h = list_heads[list_heads.size() - 1];
    wait_for_drain();
    send_word(clle_pkg::OP_INSERT, h, 1, 8'h81);
    wait_for_drain();
    send_word(clle_pkg::OP_GET, h, 1, 0);
  endtask

  task automatic test_random(input int count);
    int h, n, r, op;
    for (int t = 0; t < count; t++) begin
      no_idle = (t >= 200 && t < 300);
      h = list_heads[$urandom_range(0, list_heads.size() - 1)];
      n = chain_length(h);
      r = $urandom_range(0, 99);
      if (r < 4 && list_heads.size() < 12) begin
        send_word(clle_pkg::OP_CREATE, $urandom_range(0, 127), $urandom_range(0, 255),
                  $urandom_range(0, 255));
      end else if (r < 36 && n < 24) begin
        send_word(clle_pkg::OP_INSERT, h, ($urandom_range(0, 9) == 0)
                  ? $urandom_range(0, 255) : $urandom_range(1, n + 1),
                  $urandom_range(0, 255));
      end else if (r < 50) begin
        send_word(clle_pkg::OP_DELETE, h, ($urandom_range(0, 9) == 0 || n == 0)
                  ? $urandom_range(0, 255) : $urandom_range(1, n), 0);
      end else if (r < 60) begin
        send_word(clle_pkg::OP_GET, h, ($urandom_range(0, 9) == 0 || n == 0)
                  ? $urandom_range(0, 255) : $urandom_range(1, n), $urandom_range(0, 255));
      end else if (r < 90) begin
        op = (r < 70) ? clle_pkg::OP_LOCATE : (r < 80) ? clle_pkg::OP_PRIOR
             : clle_pkg::OP_NEXT;
        send_word(op[2:0], h, $urandom_range(0, 255), pick_value(h));
      end else if (r < 96) begin
        send_word(clle_pkg::OP_LEN_CLR, h, 0, $urandom_range(0, 255));
      end else if (r < 98) begin
        send_word(clle_pkg::OP_LEN_CLR, h, 1, $urandom_range(0, 255));
      end else begin
        send_word(clle_pkg::OP_LEN_CLR, h, $urandom_range(2, 255), $urandom_range(0, 255));
      end
    end
    no_idle = 1'b0;
  endtask

  // Response side: a long hold-off when asked for, otherwise random stalls.
  initial begin
    int stall;
    stall = 0;
    resp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        resp_if.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        resp_if.ready <= 1'b0;
      end else begin
        resp_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  // Each taken response word is checked against the oldest expectation.
  always @(posedge clk) begin
    clle_pkg::out_word_t want;
    if (!rst && resp_if.valid === 1'b1 && resp_if.ready === 1'b1) begin
      if (awaited_words.size() == 0) begin
        report_mismatch("words outstanding", 1, 0);
      end else begin
        want = awaited_words.pop_front();
        if (resp_if.data.status !== want.status)
          report_mismatch("status", resp_if.data.status, want.status);
        if (resp_if.data.slot_index !== want.slot_index)
          report_mismatch("slot_index", resp_if.data.slot_index, want.slot_index);
        if (resp_if.data.result_value !== want.result_value)
          report_mismatch("result_value", resp_if.data.result_value, want.result_value);
        if (resp_if.data.list_length !== want.list_length)
          report_mismatch("list_length", resp_if.data.list_length, want.list_length);
      end
    end
  end

  initial begin
    #15000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_next[i] = (i + 1 < SLOTS) ? i + 1 : 0;
      shadow_data[i] = 8'h00;
    end
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_pool_exhaustion();
    test_backpressure();
    test_drain_pause();
    test_random(480);
    wait_for_drain();
    repeat (300) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
